// ===== rtl/core/bdil_pkg.sv =====
package bdil_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int ROW_W      = IMG_H_W + 1;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = (EW_W > IMG_W_W) ? EW_W : IMG_W_W;

  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = IMG_W_W'(1024);
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = IMG_H_W'(1);
  localparam logic [PIX_W-1:0]   RST_FG_VALUE     = PIX_W'(255);
  localparam logic [PIX_W-1:0]   PIX_MAX          = PIX_W'(255);

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FG_VALUE     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic b;
    logic a;
  } line_flags_t;

endpackage

// ===== rtl/core/bdil_if.sv =====
interface bdil_in_if;
  logic                          valid;
  logic                          ready;
  bdil_pkg::func_e               func;
  logic [bdil_pkg::PIX_W-1:0]    pixel_in;

  modport source (output valid, func, pixel_in, input ready);
  modport sink   (input valid, func, pixel_in, output ready);
endinterface

interface bdil_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdil_pkg::PIX_W-1:0]    pixel_out;
  logic                          frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

interface bdil_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdil_pkg::CFG_IDX_W-1:0]  index;
  logic [bdil_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/binary_dilation_3x3.sv =====
// 3x3 binary dilation of a raster-order grey stream. A pixel matches when it
// equals fg_value; an output pixel is fg_value when any match lies in its
// border-clipped 3x3 neighborhood, else the background (255 for fg_value 0,
// otherwise 0). Outputs lag the input by one row plus one pixel; after the
// last pixel send image_width + 1 further transactions (flush or pixel) to
// drain the frame, frame_last marking its final output. Flush transactions
// sent while pixels are still expected are taken and dropped. One input
// transaction is taken every cycle while the sink keeps up: the 2-bit-wide
// line store of depth MAX_WIDTH is read one column ahead with write
// forwarding, and a two-entry result buffer holds the input only while both
// entries are full. A configuration write restarts the frame and must be
// issued only while the block is idle.
module binary_dilation_3x3 (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdil_in_if.sink   in_i,
  bdil_cfg_if.sink  cfg_i,
  bdil_out_if.source out_o
);
  import bdil_pkg::*;

  logic    push;
  logic    space;
  result_t result;

  bdil_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .space_i  (space),
    .push_o   (push),
    .result_o (result)
  );

  bdil_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (result),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule

// ===== rtl/core/bdil_line_store.sv =====
module bdil_line_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bdil_pkg::COL_W-1:0]    waddr_i,
  input  bdil_pkg::line_flags_t         wdata_i,
  input  logic [bdil_pkg::COL_W-1:0]    raddr_i,
  output bdil_pkg::line_flags_t         rdata_o
);
  import bdil_pkg::*;

  line_flags_t mem_q [MAX_WIDTH];
  line_flags_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // forward a same-cycle write to the prefetched column
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bdil_core.sv =====
module bdil_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  bdil_in_if.sink            in_i,
  bdil_cfg_if.sink           cfg_i,
  input  logic               space_i,
  output logic               push_o,
  output bdil_pkg::result_t  result_o
);
  import bdil_pkg::*;

  logic [IMG_W_W-1:0] image_width_q;
  logic [IMG_H_W-1:0] image_height_q;
  logic [PIX_W-1:0]   fg_value_q;

  logic [8:0]         win_q, win_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   out_col_q, out_col_d;
  logic [IMG_H_W-1:0] out_row_q, out_row_d;

  logic               cfg_we, cfg_restart;
  logic               acc, pixel_phase, drop, step, emit, hit, f, up1, up2, last_tick, last;
  logic [CMP_W-1:0]   iw_ext;
  logic [EW_W-1:0]    eff_w, col_inc, out_col_inc;
  logic [IMG_H_W-1:0] eff_h;
  logic [ROW_W-1:0]   h_ext;
  logic [2:0]         triple;
  logic [PIX_W-1:0]   bg;
  line_flags_t        rd_flags, wr_flags;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_restart = cfg_we &&
                       (cfg_i.index inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_FG_VALUE});
  assign in_i.ready  = space_i;
  assign acc         = in_i.valid && space_i;

  always_comb begin
    iw_ext = CMP_W'(image_width_q);
    if (iw_ext == '0) begin
      eff_w = EW_W'(1);
    end else if (iw_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(iw_ext);
    end
    eff_h = (image_height_q == '0) ? IMG_H_W'(1) : image_height_q;
    h_ext = ROW_W'(eff_h);
  end

  assign pixel_phase = row_q < h_ext;
  assign drop        = pixel_phase && (in_i.func == FUNC_FLUSH);
  assign step        = acc && !drop;
  assign f           = pixel_phase && (in_i.pixel_in == fg_value_q);
  assign up1         = (row_q >= ROW_W'(1)) && rd_flags.a;
  assign up2         = (row_q >= ROW_W'(2)) && rd_flags.b;
  assign triple      = {f, up1, up2};
  assign wr_flags    = '{b: rd_flags.a, a: f};
  assign last_tick   = (col_q == '0) && (row_q >= h_ext + ROW_W'(1));
  assign col_inc     = EW_W'(col_q) + EW_W'(1);
  assign out_col_inc = EW_W'(out_col_q) + EW_W'(1);
  assign last        = (out_row_q == eff_h - IMG_H_W'(1))
                    && (EW_W'(out_col_q) == eff_w - EW_W'(1));
  assign bg          = (fg_value_q == '0) ? PIX_MAX : '0;

  always_comb begin
    if (col_q == '0) begin
      win_d = {triple, 6'b0};
      emit  = row_q >= ROW_W'(2);
      hit   = win_q[8:3] != '0;
    end else begin
      win_d = {triple, win_q[8:3]};
      emit  = row_q >= ROW_W'(1);
      hit   = win_d != '0;
    end
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_restart) begin
      col_d     = '0;
      row_d     = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (step) begin
      if (last_tick) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = COL_W'(col_inc);
      end
      if (emit) begin
        if (last) begin
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_inc >= eff_w) begin
          out_col_d = '0;
          out_row_d = out_row_q + IMG_H_W'(1);
        end else begin
          out_col_d = COL_W'(out_col_inc);
        end
      end
    end
  end

  bdil_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (col_q),
    .wdata_i (wr_flags),
    .raddr_i (col_d),
    .rdata_o (rd_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      fg_value_q     <= RST_FG_VALUE;
      win_q          <= '0;
      col_q          <= '0;
      row_q          <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:  image_width_q  <= cfg_i.data[IMG_W_W-1:0];
          CFG_IMAGE_HEIGHT: image_height_q <= cfg_i.data[IMG_H_W-1:0];
          CFG_FG_VALUE:     fg_value_q     <= cfg_i.data[PIX_W-1:0];
          default: ;
        endcase
      end
      if (cfg_restart) begin
        win_q <= '0;
      end else if (step) begin
        win_q <= last_tick ? '0 : win_d;
      end
      col_q     <= col_d;
      row_q     <= row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign push_o             = step && emit && !cfg_restart;
  assign result_o.pixel_out = hit ? fg_value_q : bg;
  assign result_o.frame_last = last;

  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW_W'(col_q) < eff_w)
    else $error("input column beyond row width");

  a_last_wraps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && last |=> (out_col_q == '0) && (out_row_q == '0))
    else $error("output position not cleared after frame end");

  a_drop_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && drop && !cfg_restart |=> $stable(col_q) && $stable(row_q) && $stable(win_q))
    else $error("ignored flush changed stream state");

endmodule

// ===== rtl/core/bdil_out_buf.sv =====
module bdil_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bdil_pkg::result_t  result_i,
  output logic               space_o,
  bdil_out_if.source         out_o
);
  import bdil_pkg::*;

  localparam logic [1:0] CNT_FULL = 2'd2;

  result_t    slots_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop            = out_o.valid && out_o.ready;
  assign space_o        = cnt_q != CNT_FULL;
  assign out_o.valid    = cnt_q != '0;
  assign out_o.pixel_out  = slots_q[rd_ptr_q].pixel_out;
  assign out_o.frame_last = slots_q[rd_ptr_q].frame_last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("result pushed into full buffer");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("buffer count out of range");

endmodule
